// ----- sv/uidr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uidr_pkg
// Shared types and codes for the unique ID ring with cursor.
// ----------------------------------------------------------------------------
package uidr_pkg;

  typedef logic [2:0] status_t;
  typedef logic [1:0] func_t;

  localparam func_t FN_ADD     = 2'd0;
  localparam func_t FN_REMOVE  = 2'd1;
  localparam func_t FN_ADVANCE = 2'd2;

  localparam status_t STAT_DONE     = 3'd0;
  localparam status_t STAT_DUP      = 3'd1;
  localparam status_t STAT_NOTFOUND = 3'd2;
  localparam status_t STAT_FULL     = 3'd3;
  localparam status_t STAT_EMPTY    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_RDCUR,
    ST_RESULT
  } state_e;

endpackage

// ----- sv/uidr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uidr_ram
// Simple dual-port ID store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module uidr_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/uidr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uidr_ctrl
// Request sequencer: scans the store for an ID, appends, closes gaps by
// read-shift-write, tracks count and cursor, reads back the current entry.
// ----------------------------------------------------------------------------
module uidr_ctrl import uidr_pkg::*; #(
  parameter int CAPACITY = 32,
  parameter int ID_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  func_t                         func_i,
  input  logic [ID_BITS-1:0]            item_id_i,
  output logic                          ram_we_o,
  output logic [$clog2(CAPACITY)-1:0]   ram_waddr_o,
  output logic [ID_BITS-1:0]            ram_wdata_o,
  output logic                          ram_re_o,
  output logic [$clog2(CAPACITY)-1:0]   ram_raddr_o,
  input  logic [ID_BITS-1:0]            ram_rdata_i,
  output logic                          res_valid_o,
  input  logic                          res_take_i,
  output logic [ID_BITS-1:0]            res_id_o,
  output logic                          res_cvalid_o,
  output logic [$clog2(CAPACITY+1)-1:0] res_count_o,
  output status_t                       res_status_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_e             state_q, state_d;
  func_t              func_q, func_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   cursor_q, cursor_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic               chk_q, chk_d;
  logic [IDX_W-1:0]   chkidx_q, chkidx_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  status_t            status_q, status_d;

  logic             hit;
  logic [CNT_W-1:0] cur_inc;
  logic [CNT_W-1:0] cnt_dec;

  assign hit     = chk_q && (ram_rdata_i == id_q);
  assign cur_inc = CNT_W'(cursor_q) + CNT_W'(1);
  assign cnt_dec = count_q - CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      chk_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      chk_q    <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    id_q     <= id_d;
    scan_q   <= scan_d;
    chkidx_q <= chkidx_d;
    pos_q    <= pos_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    id_d        = id_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    scan_d      = scan_q;
    chk_d       = chk_q;
    chkidx_d    = chkidx_q;
    pos_d       = pos_q;
    status_d    = status_q;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = count_q[IDX_W-1:0];
    ram_wdata_o = id_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = scan_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          func_d   = func_i;
          id_d     = item_id_i;
          scan_d   = '0;
          chk_d    = 1'b0;
          status_d = STAT_DONE;
          state_d  = ST_RDCUR;
          case (func_i)
            FN_ADD: begin
              state_d = ST_SEARCH;
            end
            FN_REMOVE: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                state_d = ST_SEARCH;
              end
            end
            FN_ADVANCE: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else if (cur_inc >= count_q) begin
                cursor_d = '0;
              end else begin
                cursor_d = cur_inc[IDX_W-1:0];
              end
            end
            default: begin
              status_d = STAT_DONE;
            end
          endcase
        end
      end

      // one read issued per cycle, compare on the returning data
      ST_SEARCH: begin
        if (hit) begin
          pos_d = chkidx_q;
          if (func_q == FN_ADD) begin
            status_d = STAT_DUP;
            state_d  = ST_RDCUR;
          end else begin
            scan_d  = CNT_W'(chkidx_q) + CNT_W'(1);
            chk_d   = 1'b0;
            state_d = ST_SHIFT;
          end
        end else if (!chk_q && scan_q >= count_q) begin
          state_d = ST_RDCUR;
          if (func_q == FN_ADD) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              status_d = STAT_FULL;
            end else begin
              ram_we_o = 1'b1;
              count_d  = count_q + CNT_W'(1);
            end
          end else begin
            status_d = STAT_NOTFOUND;
          end
        end else if (scan_q < count_q) begin
          ram_re_o = 1'b1;
          chk_d    = 1'b1;
          chkidx_d = scan_q[IDX_W-1:0];
          scan_d   = scan_q + CNT_W'(1);
        end else begin
          chk_d = 1'b0;
        end
      end

      // entry i+1 is read, then written to i on the next cycle
      ST_SHIFT: begin
        if (chk_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = chkidx_q;
          ram_wdata_o = ram_rdata_i;
        end
        if (scan_q < count_q) begin
          ram_re_o = 1'b1;
          chk_d    = 1'b1;
          chkidx_d = IDX_W'(scan_q - CNT_W'(1));
          scan_d   = scan_q + CNT_W'(1);
        end else begin
          chk_d = 1'b0;
          if (!chk_q) begin
            count_d = cnt_dec;
            state_d = ST_RDCUR;
            if (cnt_dec == '0) begin
              cursor_d = '0;
            end else if (pos_q < cursor_q) begin
              cursor_d = cursor_q - IDX_W'(1);
            end else if (pos_q == cursor_q && CNT_W'(cursor_q) >= cnt_dec) begin
              cursor_d = '0;
            end
          end
        end
      end

      ST_RDCUR: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = cursor_q;
        state_d     = ST_RESULT;
      end

      ST_RESULT: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_cvalid_o = (count_q != '0);
  assign res_id_o     = res_cvalid_o ? ram_rdata_i : '0;
  assign res_count_o  = count_q;
  assign res_status_o = status_q;

endmodule

// ----- sv/unique_id_ring_with_cursor_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_id_ring_with_cursor_unit
// Ordered list of distinct IDs in a RAM, with a cursor to the current entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: func_i
//   (add, remove, advance) and item_id_i. Output channel (out_valid_o /
//   out_stall_i) returns exactly one result per request: current ID, valid
//   flag, entry count and status.
//   One request is worked at a time; the RAM's single read port sets the
//   pace. An add scans the list and appends when the ID is new and the
//   list is not full; a remove scans for the entry, then shifts each later
//   entry down by one place. Every request, also an advance, a no-op on an
//   empty list or an unused code, ends by reading the current entry.
//   The next request can be taken in the cycle after the result is loaded.
//   A stalled result sits in the output register; the next request is
//   accepted and worked meanwhile and waits for that register to free up.
//   Reset empties the list and parks the cursor at zero; RAM contents need
//   no clearing, only entries below the count are ever used.
// ----------------------------------------------------------------------------
module unique_id_ring_with_cursor_unit import uidr_pkg::*; #(
  parameter int CAPACITY = 32,
  parameter int ID_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [ID_BITS-1:0]            item_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ID_BITS-1:0]            current_id_o,
  output logic                          current_valid_o,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count_o,
  output logic [2:0]                    status_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ID_BITS-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ID_BITS-1:0] ram_rdata;

  logic               res_valid;
  logic               res_take;
  logic [ID_BITS-1:0] res_id;
  logic               res_cvalid;
  logic [CNT_W-1:0]   res_count;
  status_t            res_status;

  logic               out_valid_q;
  logic [ID_BITS-1:0] out_id_q;
  logic               out_cvalid_q;
  logic [CNT_W-1:0]   out_count_q;
  status_t            out_status_q;

  uidr_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(ID_BITS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  uidr_ctrl #(
    .CAPACITY(CAPACITY),
    .ID_BITS (ID_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .item_id_i   (item_id_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_id_o    (res_id),
    .res_cvalid_o(res_cvalid),
    .res_count_o (res_count),
    .res_status_o(res_status)
  );

  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      out_id_q     <= res_id;
      out_cvalid_q <= res_cvalid;
      out_count_q  <= res_count;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_id_o    = out_id_q;
  assign current_valid_o = out_cvalid_q;
  assign entry_count_o   = out_count_q;
  assign status_o        = out_status_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the unique ID ring with cursor.
// A short table of requests covers the empty list, ID extremes, duplicates,
// misses and every cursor move on remove. Random requests follow, in phases
// that grow the list to full, shrink it to empty, or mix the two. A model of
// the list predicts every result, and each result is compared field by field.
// Both handshakes see random idle cycles, except in one stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import uidr_pkg::*;

  localparam int    CAP        = 32;
  localparam int    N_RANDOM   = 1130;
  localparam func_t FN_UNUSED  = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic        valid;
    logic [5:0]  count;
    status_t     status;
  } ring_view_t;

  typedef struct packed {
    func_t       fn;
    logic [15:0] id;
    logic        typed;
    ring_view_t  want;
  } stim_row_t;

  // Expected views are typed in only where they are obvious.
  localparam stim_row_t PLAN [0:19] = '{
    '{FN_ADVANCE, 16'h0000, 1'b1, '{16'h0000, 1'b0, 6'd0, STAT_EMPTY}},
    '{FN_REMOVE,  16'h1234, 1'b1, '{16'h0000, 1'b0, 6'd0, STAT_EMPTY}},
    '{FN_UNUSED,  16'hFFFF, 1'b1, '{16'h0000, 1'b0, 6'd0, STAT_DONE}},
    '{FN_ADD,     16'h0000, 1'b1, '{16'h0000, 1'b1, 6'd1, STAT_DONE}},
    '{FN_ADD,     16'hFFFF, 1'b1, '{16'h0000, 1'b1, 6'd2, STAT_DONE}},
    '{FN_ADD,     16'hFFFF, 1'b1, '{16'h0000, 1'b1, 6'd2, STAT_DUP}},
    '{FN_REMOVE,  16'h5555, 1'b1, '{16'h0000, 1'b1, 6'd2, STAT_NOTFOUND}},
    '{FN_ADVANCE, 16'h0000, 1'b0, '0},
    '{FN_ADVANCE, 16'hFFFF, 1'b0, '0},
    '{FN_ADD,     16'hAAAA, 1'b0, '0},
    '{FN_ADD,     16'h5555, 1'b0, '0},
    '{FN_UNUSED,  16'h1234, 1'b0, '0},
    '{FN_ADVANCE, 16'h0000, 1'b0, '0},
    '{FN_REMOVE,  16'h0000, 1'b0, '0},  // entry before the cursor
    '{FN_ADVANCE, 16'h0000, 1'b0, '0},
    '{FN_ADVANCE, 16'h0000, 1'b0, '0},
    '{FN_REMOVE,  16'h5555, 1'b0, '0},  // current and last: wraps
    '{FN_REMOVE,  16'hFFFF, 1'b0, '0},  // current, moves to follower
    '{FN_REMOVE,  16'hAAAA, 1'b1, '{16'h0000, 1'b0, 6'd0, STAT_DONE}},
    '{FN_ADVANCE, 16'h0000, 1'b1, '{16'h0000, 1'b0, 6'd0, STAT_EMPTY}}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i      = '0;
  logic [15:0] item_id_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] current_id_o;
  logic        current_valid_o;
  logic [5:0]  entry_count_o;
  logic [2:0]  status_o;

  logic [15:0] ring_ids [$];
  int          cursor;
  ring_view_t  pending_views [$];
  int          mismatch_count = 0;
  bit          calm = 1'b0;

  unique_id_ring_with_cursor_unit #(
    .CAPACITY (CAP),
    .ID_BITS  (16)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .item_id_i       (item_id_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .current_id_o    (current_id_o),
    .current_valid_o (current_valid_o),
    .entry_count_o   (entry_count_o),
    .status_o        (status_o)
  );

  always #10 clk_i = ~clk_i;

  // Applies one request to the list model and returns the view after it.
  function automatic ring_view_t ring_apply(func_t fn, logic [15:0] id);
    ring_view_t v;
    int         pos;
    pos = -1;
    foreach (ring_ids[i]) if (pos < 0 && ring_ids[i] == id) pos = i;
    v.status = STAT_DONE;
    case (fn)
      FN_ADD: begin
        if (pos >= 0) v.status = STAT_DUP;
        else if (ring_ids.size() >= CAP) v.status = STAT_FULL;
        else begin
          ring_ids = {ring_ids, id};
          if (ring_ids.size() == 1) cursor = 0;
        end
      end
      FN_REMOVE: begin
        if (ring_ids.size() == 0) v.status = STAT_EMPTY;
        else if (pos < 0) v.status = STAT_NOTFOUND;
        else begin
          ring_ids.delete(pos);
          if (ring_ids.size() == 0) cursor = 0;
          else if (pos < cursor) cursor--;
          else if (pos == cursor && cursor >= ring_ids.size()) cursor = 0;
        end
      end
      FN_ADVANCE: begin
        if (ring_ids.size() == 0) v.status = STAT_EMPTY;
        else begin
          cursor++;
          if (cursor >= ring_ids.size()) cursor = 0;
        end
      end
      default: ;
    endcase
    v.valid = (ring_ids.size() > 0);
    v.id    = v.valid ? ring_ids[cursor] : 16'h0000;
    v.count = 6'(ring_ids.size());
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_request(func_t fn, logic [15:0] id, logic typed,
                               ring_view_t want);
    ring_view_t v;
    while (!calm && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      func_i     <= 2'($urandom);
      item_id_i  <= 16'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    item_id_i  <= id;
    do @(posedge clk_i); while (in_stall_o);
    v = ring_apply(fn, id);
    pending_views = {pending_views, (typed ? want : v)};
    @(negedge clk_i);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field,
             got, want);
    mismatch_count++;
  endtask

  always @(negedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 35);

  always @(posedge clk_i) begin
    ring_view_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_views.size() == 0) begin
        report_mismatch("result with no request pending", current_id_o, 0);
      end else begin
        want = pending_views.pop_front();
        if (current_id_o !== want.id)
          report_mismatch("current_id", current_id_o, want.id);
        if (current_valid_o !== want.valid)
          report_mismatch("current_valid", current_valid_o, want.valid);
        if (entry_count_o !== want.count)
          report_mismatch("entry_count", entry_count_o, want.count);
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
      end
    end
  end

  initial begin
    int          sent;
    int          mode;
    int          span;
    int          r;
    func_t       fn;
    logic [15:0] id;
    cursor = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (PLAN[i]) issue_request(PLAN[i].fn, PLAN[i].id, PLAN[i].typed, PLAN[i].want);

    // Phases: 0 grows toward full, 1 drains toward empty, 2 mixes.
    sent = 0;
    while (sent < N_RANDOM) begin
      mode = $urandom_range(2);
      span = $urandom_range(40, 120);
      for (int k = 0; k < span && sent < N_RANDOM; k++) begin
        calm = (sent >= 500 && sent < 700);
        r = $urandom_range(99);
        case (mode)
          0:       fn = (r < 70) ? FN_ADD : (r < 80) ? FN_REMOVE :
                        (r < 95) ? FN_ADVANCE : FN_UNUSED;
          1:       fn = (r < 15) ? FN_ADD : (r < 75) ? FN_REMOVE :
                        (r < 95) ? FN_ADVANCE : FN_UNUSED;
          default: fn = (r < 40) ? FN_ADD : (r < 70) ? FN_REMOVE :
                        (r < 95) ? FN_ADVANCE : FN_UNUSED;
        endcase
        // Mostly a small ID pool so duplicates and hits are common.
        if (fn == FN_REMOVE && ring_ids.size() > 0 && $urandom_range(99) < 75)
          id = ring_ids[$urandom_range(ring_ids.size() - 1)];
        else if ($urandom_range(99) < 70)
          id = 16'($urandom_range(47) * 16'h0557);
        else
          id = 16'($urandom);
        issue_request(fn, id, 1'b0, '0);
        sent++;
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
